// ===== rtl/utf8v_pkg.sv =====
// Shared types, constants and the FNV-1a step for the UTF-8 name validator.
// No dependencies; used by every module of the block.
package utf8v_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [7:0] BYTE_SPACE  = 8'h20;
  localparam logic [7:0] BYTE_DEL    = 8'h7f;
  localparam logic [7:0] LEAD2_LO    = 8'hc2;
  localparam logic [7:0] LEAD2_HI    = 8'hdf;
  localparam logic [7:0] LEAD3_LO    = 8'he0;
  localparam logic [7:0] LEAD3_HI    = 8'hef;
  localparam logic [7:0] LEAD4_LO    = 8'hf0;
  localparam logic [7:0] LEAD4_HI    = 8'hf4;
  localparam logic [7:0] LEAD_E0     = 8'he0;
  localparam logic [7:0] LEAD_ED     = 8'hed;
  localparam logic [7:0] LEAD_F0     = 8'hf0;
  localparam logic [7:0] LEAD_F4     = 8'hf4;
  localparam logic [7:0] CONT_MASK   = 8'hc0;
  localparam logic [7:0] CONT_TAG    = 8'h80;
  localparam logic [7:0] SECOND_A0   = 8'ha0;
  localparam logic [7:0] SECOND_90   = 8'h90;
  localparam logic [7:0] COUNT_SAT   = 8'hff;
  localparam logic [7:0] MAX_LEN_RST = 8'd64;

  typedef enum logic [2:0] {
    CLASS_NONE = 3'd0,
    CLASS_E0   = 3'd1,
    CLASS_ED   = 3'd2,
    CLASS_F0   = 3'd3,
    CLASS_F4   = 3'd4
  } lead_class_t;

  typedef struct packed {
    logic [31:0] hash;
    logic [7:0]  count;
    logic [1:0]  cont_left;
    lead_class_t lead;
    logic        expect_second;
    logic        err;
  } name_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic        name_valid;
    logic [31:0] name_hash;
    logic [7:0]  name_length;
  } result_t;

  localparam name_state_t STATE_CLEAR = '{
    hash: FNV_BASIS, count: 8'd0, cont_left: 2'd0, lead: CLASS_NONE,
    expect_second: 1'b0, err: 1'b0
  };

  // prime = 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// ===== rtl/utf8v_in_reg.sv =====
// Input register: holds one accepted word until the step logic takes it.
// Depends on utf8v_pkg.
module utf8v_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] name_byte
  input  logic              in_tlast,   // last_byte
  input  logic              advance,
  output utf8v_pkg::in_word_t word
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       load;

  assign in_tready = !valid_r || advance;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  assign word.valid = valid_r;
  assign word.data  = data_r;
  assign word.last  = last_r;

endmodule

// ===== rtl/utf8v_step.sv =====
// Per-byte update: length check, FNV-1a fold, UTF-8 decode and end-of-name checks.
// Purely combinational; depends on utf8v_pkg.
module utf8v_step (
  input  utf8v_pkg::name_state_t st,
  input  logic [7:0]             b,
  input  logic                   last,
  input  logic [7:0]             max_length,
  output utf8v_pkg::name_state_t st_nxt,
  output utf8v_pkg::result_t     res
);

  utf8v_pkg::name_state_t s;

  always_comb begin
    s      = st;
    s.hash = utf8v_pkg::fnv_step(st.hash, b);

    if (st.count == 8'd0 && b == utf8v_pkg::BYTE_SPACE) begin
      s.err = 1'b1;
    end

    if (st.count == utf8v_pkg::COUNT_SAT) begin
      s.err = 1'b1;
    end else begin
      s.count = st.count + 8'd1;
      if (s.count > max_length) begin
        s.err = 1'b1;
      end
    end

    if (st.cont_left != 2'd0) begin
      if ((b & utf8v_pkg::CONT_MASK) != utf8v_pkg::CONT_TAG) begin
        s.err = 1'b1;
      end
      if (st.expect_second) begin
        if ((st.lead == utf8v_pkg::CLASS_E0 && b <  utf8v_pkg::SECOND_A0) ||
            (st.lead == utf8v_pkg::CLASS_ED && b >= utf8v_pkg::SECOND_A0) ||
            (st.lead == utf8v_pkg::CLASS_F0 && b <  utf8v_pkg::SECOND_90) ||
            (st.lead == utf8v_pkg::CLASS_F4 && b >= utf8v_pkg::SECOND_90)) begin
          s.err = 1'b1;
        end
        s.expect_second = 1'b0;
      end
      s.cont_left = st.cont_left - 2'd1;
    end else begin
      s.lead = utf8v_pkg::CLASS_NONE;
      if (b inside {[8'h00:8'h7f]}) begin
        if (b < utf8v_pkg::BYTE_SPACE || b == utf8v_pkg::BYTE_DEL) begin
          s.err = 1'b1;
        end
      end else if (b inside {[utf8v_pkg::LEAD2_LO:utf8v_pkg::LEAD2_HI]}) begin
        s.cont_left     = 2'd1;
        s.expect_second = 1'b1;
      end else if (b inside {[utf8v_pkg::LEAD3_LO:utf8v_pkg::LEAD3_HI]}) begin
        s.cont_left     = 2'd2;
        s.expect_second = 1'b1;
        if (b == utf8v_pkg::LEAD_E0) begin
          s.lead = utf8v_pkg::CLASS_E0;
        end else if (b == utf8v_pkg::LEAD_ED) begin
          s.lead = utf8v_pkg::CLASS_ED;
        end
      end else if (b inside {[utf8v_pkg::LEAD4_LO:utf8v_pkg::LEAD4_HI]}) begin
        s.cont_left     = 2'd3;
        s.expect_second = 1'b1;
        if (b == utf8v_pkg::LEAD_F0) begin
          s.lead = utf8v_pkg::CLASS_F0;
        end else if (b == utf8v_pkg::LEAD_F4) begin
          s.lead = utf8v_pkg::CLASS_F4;
        end
      end else begin
        s.err = 1'b1;
      end
    end

    if (last && (b == utf8v_pkg::BYTE_SPACE || s.cont_left != 2'd0)) begin
      s.err = 1'b1;
    end

    res.name_valid  = !s.err;
    res.name_hash   = s.hash;
    res.name_length = s.count;
    st_nxt          = last ? utf8v_pkg::STATE_CLEAR : s;
  end

endmodule

// ===== rtl/utf8_name_validator_fnv1a_top.sv =====
// Top level of the UTF-8 display-name validator with FNV-1a 32-bit hash.
// Instantiates utf8v_in_reg and utf8v_step; depends on utf8v_pkg.
//
// Usage:
//   Input stream: one name byte per word on in_tdata, in_tlast on the final
//   byte. A name must hold at least one byte. Result stream: one word per
//   name. out_tuser is the pass flag, out_tdata carries the hash and the
//   saturated byte count. cfg_wr_en / cfg_wr_data write max_length (reset
//   64) only while the block idles, a user rule the block does not enforce.
// Timing:
//   One byte per cycle sustained unless a final byte waits for the output
//   register, set by the state loop (hash multiply by shifts and adds,
//   decode). A byte waits in the input register; the result of a final byte
//   is registered from there into the output register, where it can be taken.
// Reset: clears the name state and the valid flags of the input and output
//   registers, and sets max_length to 64.
// Stall: non-final bytes keep flowing while a result waits. A final byte
//   waits in the input register until the output register is free, and
//   in_tready drops behind it.
module utf8_name_validator_fnv1a_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] name_byte
  input  logic        in_tlast,    // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [31:0] name_hash, [39:32] name_length
  output logic        out_tuser,   // name_valid
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  utf8v_pkg::in_word_t    word;
  utf8v_pkg::name_state_t state_r, state_nxt;
  utf8v_pkg::result_t     res, res_r;
  logic                   advance;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             max_length_r;

  assign advance = word.valid && (!word.last || !out_valid_r || out_tready);

  utf8v_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .advance   (advance),
    .word      (word)
  );

  utf8v_step u_step (
    .st         (state_r),
    .b          (word.data),
    .last       (word.last),
    .max_length (max_length_r),
    .st_nxt     (state_nxt),
    .res        (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && word.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= utf8v_pkg::STATE_CLEAR;
      out_valid_r  <= 1'b0;
      max_length_r <= utf8v_pkg::MAX_LEN_RST;
    end else begin
      if (advance) begin
        state_r <= state_nxt;
      end
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_length_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && word.last) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.name_valid;
  assign out_tdata  = {res_r.name_length, res_r.name_hash};

  a_ready_low_only_behind_final: assert property (
    @(posedge clk) disable iff (!rst_n)
    !in_tready |-> word.valid && word.last && out_valid_r && !out_tready
  ) else $error("input blocked without a waiting final byte");

  a_state_cleared_after_name: assert property (
    @(posedge clk) disable iff (!rst_n)
    advance && word.last |=> state_r.count == 8'd0 && !state_r.err &&
                             state_r.cont_left == 2'd0
  ) else $error("name state not cleared after final byte");

  a_result_drained: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tready && !(advance && word.last) |=> !out_valid_r
  ) else $error("result repeated after being taken");

endmodule
